/* rtl/core/ahc_pkg.sv */
// shared constants and types of the anagram histogram checker
// no dependencies
package ahc_pkg;

	localparam int MAX_LEN  = 128;
	localparam int ALPHABET = 256;

	localparam int ADDR_W = $clog2(ALPHABET);
	localparam int BIN_W  = 9;
	localparam int LEN_W  = 8;
	localparam int CNT_W  = 9;
	localparam int SYM_W  = 8;
	localparam int MODE_W = 2;

	localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SECOND = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

	typedef logic signed [BIN_W-1:0] bin_t;

	// one bin update waiting for its read data
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
		logic              dec;
	} upd_req_t;

	// write-back of an updated bin
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		bin_t              data;
	} bin_wr_t;

endpackage

/* rtl/core/ahc_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module ahc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/ahc_bin_update.sv */
// bin read-modify-write stage: forwarding, +/-1 and nonzero bin count
// depends on ahc_pkg
module ahc_bin_update (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ahc_pkg::upd_req_t             req,
	input  ahc_pkg::bin_t                 rdata,
	input  logic                          clr,
	output ahc_pkg::bin_wr_t              wr,
	output logic [ahc_pkg::CNT_W-1:0]     nz_count
);
	import ahc_pkg::*;

	logic              fwd_valid_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	bin_t              fwd_data_q;
	logic [CNT_W-1:0]  count_q;
	bin_t              cur_bin;
	bin_t              after;
	logic              fwd_hit;

	// write of the previous cycle is not yet visible in the read data
	assign fwd_hit = fwd_valid_q && (fwd_addr_q == req.addr);
	assign cur_bin = fwd_hit ? fwd_data_q : rdata;
	assign after   = req.dec ? (cur_bin - BIN_W'(1)) : (cur_bin + BIN_W'(1));

	assign wr.en    = req.valid;
	assign wr.addr  = req.addr;
	assign wr.data  = after;
	assign nz_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= req.addr;
		fwd_data_q <= after;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			priority if (clr) begin
				count_q <= '0;
			end else if (req.valid && cur_bin == '0) begin
				count_q <= count_q + CNT_W'(1);
			end else if (req.valid && after == '0) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ALPHABET))
		else $error("nonzero bin count above alphabet size");

	a_clr_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> count_q == '0)
		else $error("nonzero bin count not cleared");

	a_no_update_on_clr: assert property (@(posedge clk) disable iff (!arst_n)
		!(clr && req.valid))
		else $error("bin update during finish");
`endif

endmodule

/* rtl/core/anagram_histogram_checker.sv */
// anagram checker on a signed difference histogram held in a 256 x 9 bit ram
// depends on ahc_pkg, ahc_ram, ahc_bin_update
//
// Each request carries a mode and a symbol. A first-string character adds one
// to the bin of its byte, a second-string character subtracts one, and a
// running count tracks how many bins are nonzero. A finish request produces
// one result: is_anagram when every bin is zero and no string ran past
// MAX_LEN characters, too_long when one did. Characters past MAX_LEN are
// dropped; mode 3 is ignored and gives no result. Character requests are
// taken one per cycle while in_ready is high: the bin is read from the ram
// in the accept cycle and written back in the following cycle, with the
// last write forwarded when the same byte repeats. A finish waits in stage 1
// until the previous result has been taken, then forms its result and is
// followed by a clearing pass that writes zero to all ALPHABET bins, one per
// cycle, during which in_ready is low. The same pass runs after reset before
// the first request is taken.
module anagram_histogram_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ahc_pkg::MODE_W-1:0]    mode,
	input  logic [ahc_pkg::SYM_W-1:0]     symbol,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          is_anagram,
	output logic                          too_long
);
	import ahc_pkg::*;

	typedef enum logic [1:0] {
		ST_RUN   = 2'b01,
		ST_CLEAR = 2'b10
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// length bookkeeping per string
	logic [LEN_W-1:0]  first_len_q;
	logic [LEN_W-1:0]  second_len_q;
	logic              ovf_q;

	// stage 1: request waiting for its ram read data
	upd_req_t          upd_s1;
	logic              fin_s1;

	// result register parts the output from the request side
	logic              out_valid_q;
	logic              is_anagram_q;
	logic              too_long_q;

	logic              accept;
	logic              is_first;
	logic              is_second;
	logic              is_char;
	logic              in_alpha;
	logic [LEN_W-1:0]  len_sel;
	logic              room;
	logic              count_it;
	logic              ovf_it;
	logic              fin_go;
	logic              clearing;
	logic              clr_last;

	bin_wr_t           wr;
	logic [CNT_W-1:0]  nz_count;
	logic [BIN_W-1:0]  ram_rdata;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [BIN_W-1:0]  ram_wdata;

	assign clearing = (state_q == ST_CLEAR);
	assign clr_last = (clr_addr_q == ADDR_W'(ALPHABET - 1));

	// no new request while a finish is pending or the bins are being cleared
	assign in_ready = (state_q == ST_RUN) && !fin_s1;
	assign accept   = in_valid && in_ready;

	assign is_first  = (mode == MODE_FIRST);
	assign is_second = (mode == MODE_SECOND);
	assign is_char   = is_first || is_second;
	assign in_alpha  = ({1'b0, symbol} < (SYM_W + 1)'(ALPHABET));
	assign len_sel   = is_first ? first_len_q : second_len_q;
	assign room      = (len_sel < LEN_W'(MAX_LEN));
	assign count_it  = accept && is_char && in_alpha && room;
	assign ovf_it    = accept && is_char && in_alpha && !room;

	// finish leaves stage 1 once the result register is free
	assign fin_go = fin_s1 && (!out_valid_q || out_ready);

	// ram write port: clearing pass or bin write-back
	assign ram_we    = clearing || wr.en;
	assign ram_waddr = clearing ? clr_addr_q : wr.addr;
	assign ram_wdata = clearing ? '0 : wr.data;

	ahc_ram #(
		.WIDTH (BIN_W),
		.DEPTH (ALPHABET)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (symbol[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	ahc_bin_update u_update (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (upd_s1),
		.rdata    (ram_rdata),
		.clr      (fin_go),
		.wr       (wr),
		.nz_count (nz_count)
	);

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s1 <= '0;
			fin_s1 <= 1'b0;
		end else begin
			upd_s1.valid <= count_it;
			upd_s1.addr  <= symbol[ADDR_W-1:0];
			upd_s1.dec   <= is_second;
			if (accept && mode == MODE_FINISH) begin
				fin_s1 <= 1'b1;
			end else if (fin_go) begin
				fin_s1 <= 1'b0;
			end
		end
	end

	// string lengths and overflow flag, cleared when the pair finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_len_q  <= '0;
			second_len_q <= '0;
			ovf_q        <= 1'b0;
		end else begin
			priority if (fin_go) begin
				first_len_q  <= '0;
				second_len_q <= '0;
				ovf_q        <= 1'b0;
			end else begin
				if (count_it && is_first) begin
					first_len_q <= first_len_q + LEN_W'(1);
				end
				if (count_it && is_second) begin
					second_len_q <= second_len_q + LEN_W'(1);
				end
				if (ovf_it) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// clearing sequencer, also run straight out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (fin_go) begin
						state_q    <= ST_CLEAR;
						clr_addr_q <= '0;
					end
				end
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_last) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			priority if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			is_anagram_q <= !ovf_q && (nz_count == '0);
			too_long_q   <= ovf_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign is_anagram = is_anagram_q;
	assign too_long   = too_long_q;

`ifndef SYNTHESIS
	a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !in_ready)
		else $error("request taken during clearing pass");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fin_s1))
		else $error("result without a finish");

	a_finish_starts_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> clearing && first_len_q == '0 && second_len_q == '0 && !ovf_q)
		else $error("finish did not reset pair state");

	a_update_only_running: assert property (@(posedge clk) disable iff (!arst_n)
		upd_s1.valid |-> !clearing && !fin_s1)
		else $error("bin update overlaps finish or clearing");
`endif

endmodule

/* tb/ahc_verdict_checker.sv */
// verdict checker for the anagram histogram checker: tracks the difference histogram of
// accepted requests, predicts each finish result and compares it with the output channel
// depends on ahc_pkg
module ahc_verdict_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [ahc_pkg::MODE_W-1:0] mode,
	input  logic [ahc_pkg::SYM_W-1:0]  symbol,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic                       is_anagram,
	input  logic                       too_long,
	output int                         mismatches,
	output int                         waiting
);
	timeunit 1ns;
	timeprecision 1ps;
	import ahc_pkg::*;

	typedef struct packed {
		logic is_anagram;
		logic too_long;
	} verdict_t;

	verdict_t         verdicts_due[$];
	bin_t             diff_hist[ALPHABET];
	logic [CNT_W-1:0] live_bins;
	logic [LEN_W-1:0] len_first;
	logic [LEN_W-1:0] len_second;
	logic             overrun;
	int               err_tally = 0;
	int               due_count = 0;

	assign mismatches = err_tally;
	assign waiting    = due_count;

	task automatic wipe_tally();
		for (int i = 0; i < ALPHABET; i++)
			diff_hist[i] = '0;
		live_bins  = '0;
		len_first  = '0;
		len_second = '0;
		overrun    = 1'b0;
	endtask

	// one character: count it, or mark the string as overrun when already full
	task automatic tally_char(input logic [SYM_W-1:0] sym, input logic second);
		bin_t was;
		bin_t now;
		if (second ? (len_second >= MAX_LEN) : (len_first >= MAX_LEN)) begin
			overrun = 1'b1;
			return;
		end
		if (second)
			len_second++;
		else
			len_first++;
		was = diff_hist[sym];
		now = second ? bin_t'(was - 9'sd1) : bin_t'(was + 9'sd1);
		if (was == 0 && now != 0)
			live_bins++;
		else if (was != 0 && now == 0)
			live_bins--;
		diff_hist[sym] = now;
	endtask

	task automatic take_request(input logic [MODE_W-1:0] m, input logic [SYM_W-1:0] sym);
		verdict_t v;
		case (m)
			MODE_FINISH: begin
				v.too_long   = overrun;
				v.is_anagram = !overrun && (live_bins == 0);
				verdicts_due.push_back(v);
				wipe_tally();
			end
			MODE_FIRST, MODE_SECOND: begin
				if (int'(sym) < ALPHABET)
					tally_char(sym, m == MODE_SECOND);
			end
			default: ;
		endcase
	endtask

	task automatic check_result();
		verdict_t want;
		if (verdicts_due.size() == 0) begin
			$display("%0t: unexpected result, expected none, got is_anagram %0b too_long %0b",
				$time, is_anagram, too_long);
			err_tally++;
		end else begin
			want = verdicts_due.pop_front();
			if (is_anagram !== want.is_anagram) begin
				$display("%0t: is_anagram expected %0b got %0b",
					$time, want.is_anagram, is_anagram);
				err_tally++;
			end
			if (too_long !== want.too_long) begin
				$display("%0t: too_long expected %0b got %0b",
					$time, want.too_long, too_long);
				err_tally++;
			end
		end
	endtask

	// a finish taken at this edge cannot be the result leaving at it, so check first
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_tally();
			verdicts_due.delete();
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				take_request(mode, symbol);
		end
		due_count = verdicts_due.size();
	end

endmodule

/* tb/tb.sv */
// top of the anagram histogram checker testbench: clock, reset, bursty request stimulus,
// receiver stall patterns and the verdict
// depends on ahc_pkg, the anagram_histogram_checker rtl and ahc_verdict_checker
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ahc_pkg::*;

	// mode 3 has no meaning and must be swallowed without a result
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1400;

	typedef struct {
		logic [MODE_W-1:0] m;
		logic [SYM_W-1:0]  s;
	} req_t;

	typedef enum {PAIR_MATCH, PAIR_NEAR, PAIR_OVERRUN, PAIR_EXTREME, PAIR_NOISE} pair_kind_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [MODE_W-1:0] mode;
	logic [SYM_W-1:0]  symbol;
	logic              out_valid;
	logic              out_ready;
	logic              is_anagram;
	logic              too_long;
	int                mismatches;
	int                waiting;

	// handshake between stimulus and receiver for the long hold-off
	bit                hold_off_go = 1'b0;
	int                burst_left  = 0;
	int                sent        = 0;
	req_t              seq[$];

	anagram_histogram_checker dut (.*);
	ahc_verdict_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// safety net: far beyond the slowest legal run (every request a finish, full stalls)
	initial begin
		#20_000_000;
		$display("tb: done, errors");
		$finish;
	end

	// present one request and hold it until the block takes it
	task automatic push_req(input logic [MODE_W-1:0] m, input logic [SYM_W-1:0] s);
		@(negedge clk);
		in_valid <= 1'b1;
		mode     <= m;
		symbol   <= s;
		do @(posedge clk); while (!in_ready);
	endtask

	// bursts of random length, random gaps between them, sometimes no gap at all
	task automatic send(input logic [MODE_W-1:0] m, input logic [SYM_W-1:0] s);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 99) < 15) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		burst_left--;
		push_req(m, s);
		if (m != MODE_UNUSED)
			sent++;
	endtask

	// stop offering and wait until every predicted result has been taken
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (waiting != 0) @(negedge clk);
	endtask

	// send the queued requests, optionally sprinkled with ignored mode 3 requests
	task automatic play_seq(input bit sprinkle);
		foreach (seq[i]) begin
			if (sprinkle && $urandom_range(0, 99) < 3)
				send(MODE_UNUSED, 8'($urandom));
			send(seq[i].m, seq[i].s);
		end
		seq.delete();
	endtask

	task automatic add(input logic [MODE_W-1:0] m, input logic [SYM_W-1:0] s);
		seq.push_back('{m: m, s: s});
	endtask

	// one string pair of the given kind, interleaved, then a finish, or random noise
	task automatic make_pair(input pair_kind_t kind);
		logic [SYM_W-1:0] a[$];
		logic [SYM_W-1:0] b[$];
		logic [SYM_W-1:0] base;
		logic [SYM_W-1:0] t;
		bit               narrow;
		int               la;
		int               lb;
		int               i;
		int               j;
		base   = 8'($urandom);
		// a narrow pool piles counts onto a few bins
		narrow = ($urandom_range(0, 2) == 0);
		if (kind == PAIR_NOISE) begin
			repeat ($urandom_range(1, 10))
				add(MODE_W'($urandom_range(0, 3)), 8'($urandom));
			if ($urandom_range(0, 9) < 7)
				add(MODE_FINISH, 8'($urandom));
			return;
		end
		case (kind)
			PAIR_MATCH, PAIR_NEAR: begin
				la = ($urandom_range(0, 19) == 0) ? $urandom_range(13, MAX_LEN)
					: $urandom_range(0, 12);
				repeat (la)
					a.push_back(narrow ? base ^ 8'($urandom_range(0, 3)) : 8'($urandom));
				b = a;
			end
			PAIR_OVERRUN: begin
				// lengths either side of the bound, one or both strings may overrun
				la = $urandom_range(MAX_LEN - 2, MAX_LEN + 3);
				lb = $urandom_range(MAX_LEN - 2, MAX_LEN + 3);
				repeat (la)
					a.push_back(base ^ 8'($urandom_range(0, 3)));
				b = a;
				while (b.size() > lb) void'(b.pop_back());
				while (b.size() < lb) b.push_back(base ^ 8'($urandom_range(0, 3)));
			end
			default: begin
				// full strings on two bins: one bin at plus the bound, one at minus
				repeat (MAX_LEN) a.push_back(base);
				repeat (MAX_LEN) b.push_back(~base);
			end
		endcase
		// shuffle the second string
		for (i = b.size() - 1; i > 0; i--) begin
			j    = $urandom_range(0, i);
			t    = b[i];
			b[i] = b[j];
			b[j] = t;
		end
		// near miss: one swapped letter, one missing, or one extra
		if (kind == PAIR_NEAR) begin
			case ($urandom_range(0, 2))
				0: begin
					if (b.size() > 0)
						b[$urandom_range(0, b.size() - 1)] ^= 8'($urandom_range(1, 255));
					else
						a.push_back(base);
				end
				1: begin
					if (b.size() > 0)
						void'(b.pop_back());
					else
						b.push_back(base);
				end
				default: a.push_back(narrow ? base ^ 8'($urandom_range(0, 3)) : 8'($urandom));
			endcase
		end
		// interleave so bins swing both ways before they settle
		i = 0;
		j = 0;
		while (i < a.size() || j < b.size()) begin
			if (j >= b.size() || (i < a.size() && $urandom_range(0, 1) == 1)) begin
				add(MODE_FIRST, a[i]);
				i++;
			end else begin
				add(MODE_SECOND, b[j]);
				j++;
			end
		end
		add(MODE_FINISH, 8'($urandom));
	endtask

	// receiver: changing stall patterns, plus one long hold-off to back the block up
	initial begin
		int  style;
		int  len;
		int  cyc;
		bit  held;
		out_ready = 1'b0;
		held      = 1'b0;
		cyc       = 0;
		@(posedge arst_n);
		forever begin
			if (hold_off_go && !held) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (400) @(negedge clk);
				held = 1'b1;
			end
			style = $urandom_range(0, 3);
			len   = $urandom_range(20, 200);
			repeat (len) begin
				@(negedge clk);
				cyc++;
				case (style)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (cyc % 5 != 0);
				endcase
			end
		end
	end

	// stimulus and verdict
	initial begin
		int         pair_no;
		bit         paused;
		int         pick;
		pair_kind_t kind;
		in_valid = 1'b0;
		mode     = MODE_FIRST;
		symbol   = '0;
		arst_n   = 1'b0;
		paused   = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty pair
		add(MODE_FINISH, 8'h00);
		// zero byte counts like any other character
		add(MODE_FIRST, 8'h00);
		add(MODE_SECOND, 8'h00);
		add(MODE_FINISH, 8'hff);
		// top byte against bottom byte
		add(MODE_FIRST, 8'hff);
		add(MODE_SECOND, 8'h00);
		add(MODE_FINISH, 8'h5a);
		// unused mode only, so the pair is still empty
		add(MODE_UNUSED, 8'hff);
		add(MODE_UNUSED, 8'h00);
		add(MODE_FINISH, 8'ha5);
		// same letters, unequal lengths
		add(MODE_FIRST, 8'h61);
		add(MODE_FIRST, 8'h61);
		add(MODE_SECOND, 8'h61);
		add(MODE_FINISH, 8'h00);
		// second string leads, bins go negative before balancing
		add(MODE_SECOND, 8'haa);
		add(MODE_SECOND, 8'h55);
		add(MODE_FIRST, 8'h55);
		add(MODE_FIRST, 8'haa);
		add(MODE_FINISH, 8'h00);
		// repeats of one byte exercise the write forwarding when they go back to back
		add(MODE_FIRST, 8'h3c);
		add(MODE_FIRST, 8'h3c);
		add(MODE_SECOND, 8'h3c);
		add(MODE_SECOND, 8'h3c);
		add(MODE_FINISH, 8'hc3);
		// a symbol past the alphabet cannot be formed: 8 bit symbols, 256 bins
		play_seq(1'b0);
		drain();

		sent    = 0;
		pair_no = 0;
		while (sent < RANDOM_ITEMS) begin
			if (!hold_off_go && sent >= 300)
				hold_off_go = 1'b1;
			if (!paused && sent >= 900) begin
				drain();
				paused = 1'b1;
			end
			// make sure the overrun and the full-swing pairs come up early
			pick = $urandom_range(0, 99);
			if (pair_no == 0)
				kind = PAIR_OVERRUN;
			else if (pair_no == 1)
				kind = PAIR_EXTREME;
			else if (pick < 55)
				kind = PAIR_MATCH;
			else if (pick < 80)
				kind = PAIR_NEAR;
			else if (pick < 83)
				kind = PAIR_OVERRUN;
			else if (pick < 84)
				kind = PAIR_EXTREME;
			else
				kind = PAIR_NOISE;
			make_pair(kind);
			play_seq(1'b1);
			pair_no++;
		end

		drain();
		// room for a trailing clearing pass and any stray result
		repeat (300) @(negedge clk);
		if (mismatches == 0 && waiting == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
